/* design/lpg_pkg.sv */
`timescale 1ns / 1ps

package lpg_pkg;

  // Default field widths.
  localparam int COORD_BITS_DEF = 11;
  localparam int COLOR_BITS_DEF = 32;

  // Fixed widths of the width register and the framebuffer address.
  localparam int WIDTH_BITS = 12;
  localparam int ADDR_BITS  = 22;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 12'd640;

  // Configuration port.
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam logic REG_SCREEN_WIDTH = 1'b0;

  // Request codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
  } lpg_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic nonzero;
    logic last;
  } lpg_status_t;

endpackage

/* design/lpg_ctrl.sv */
`timescale 1ns / 1ps

module lpg_ctrl
  import lpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  output logic        out_valid,
  input  logic        out_stall,
  input  lpg_status_t sts,
  output lpg_cmd_t    ctl
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_ACTIVE = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic accept;

  // A new request may enter unless a finished pixel is still held.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign ctl.load = accept & (cmd == CMD_LOAD);
  assign ctl.step = accept & (cmd == CMD_STEP) & (state == ST_ACTIVE);

  always_comb begin
    state_next = state;
    if (ctl.load) begin
      state_next = sts.nonzero ? ST_ACTIVE : ST_IDLE;
    end else if (ctl.step && sts.last) begin
      state_next = ST_IDLE;
    end
  end

  always_comb begin
    if (ctl.step) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    ctl.step && sts.last |=> state == ST_IDLE)
    else $error("line still active after its final pixel");

  a_empty_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load && !sts.nonzero |=> state == ST_IDLE)
    else $error("zero-length line became active");

  a_step_gives_pixel: assert property (@(posedge clk) disable iff (rst)
    ctl.step |=> out_valid)
    else $error("step produced no pixel");

  a_held_pixel_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled pixel was dropped");
`endif

endmodule

/* design/lpg_datapath.sv */
`timescale 1ns / 1ps

module lpg_datapath
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lpg_cmd_t              ctl,
  output lpg_status_t           sts,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COLOR_BITS-1:0] line_color,
  output logic [COORD_BITS-1:0] pix_x,
  output logic [COORD_BITS-1:0] pix_y,
  output logic [ADDR_BITS-1:0]  pix_addr,
  output logic [COLOR_BITS-1:0] pix_color,
  output logic                  last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata
);

  localparam int ERR_BITS  = COORD_BITS + 3;
  localparam int STEP_BITS = COORD_BITS + 2;
  localparam int PROD_BITS = COORD_BITS + WIDTH_BITS;
  localparam int SUM_BITS  = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;

  logic [WIDTH_BITS-1:0] screen_width;

  logic [COORD_BITS-1:0] major_pos;
  logic [COORD_BITS-1:0] minor_pos;
  logic [COORD_BITS-1:0] major_end;
  logic [ERR_BITS-1:0]   err_acc;
  logic [STEP_BITS-1:0]  err_inc;
  logic [STEP_BITS-1:0]  err_dec;
  logic                  major_down;
  logic                  minor_down;
  logic                  steep;
  logic [COLOR_BITS-1:0] held_color;

  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  ld_steep;
  logic [COORD_BITS-1:0] ld_major_abs;
  logic [COORD_BITS-1:0] ld_minor_abs;

  logic [COORD_BITS-1:0] next_major;
  logic [COORD_BITS-1:0] next_minor;
  logic [ERR_BITS-1:0]   err_sum;
  logic                  minor_move;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [PROD_BITS-1:0]  row_base;
  logic [SUM_BITS-1:0]   addr_sum;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= WIDTH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SCREEN_WIDTH) begin
      screen_width <= pwdata[WIDTH_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SCREEN_WIDTH) ?
                  PDATA_BITS'(screen_width) : '0;

  // Octant setup from the endpoint deltas.
  assign adx          = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
  assign ady          = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
  assign ld_steep     = ady > adx;
  assign ld_major_abs = ld_steep ? ady : adx;
  assign ld_minor_abs = ld_steep ? adx : ady;

  // One Bresenham step.
  assign next_major = major_down ? (major_pos - 1'b1) : (major_pos + 1'b1);
  assign err_sum    = err_acc + {1'b0, err_inc};
  assign minor_move = ~err_sum[ERR_BITS-1];
  assign next_minor = minor_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);

  assign cur_x    = steep ? minor_pos : major_pos;
  assign cur_y    = steep ? major_pos : minor_pos;
  assign row_base = cur_y * screen_width;
  assign addr_sum = SUM_BITS'(row_base) + SUM_BITS'(cur_x);

  assign sts.nonzero = (adx != '0) || (ady != '0);
  assign sts.last    = next_major == major_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      major_pos  <= '0;
      minor_pos  <= '0;
      major_end  <= '0;
      err_acc    <= '0;
      err_inc    <= '0;
      err_dec    <= '0;
      major_down <= 1'b0;
      minor_down <= 1'b0;
      steep      <= 1'b0;
      held_color <= '0;
    end else if (ctl.load) begin
      steep      <= ld_steep;
      major_pos  <= ld_steep ? start_y : start_x;
      major_end  <= ld_steep ? end_y : end_x;
      minor_pos  <= ld_steep ? start_x : start_y;
      major_down <= ld_steep ? (start_y > end_y) : (start_x > end_x);
      minor_down <= ld_steep ? (start_x > end_x) : (start_y > end_y);
      err_inc    <= {1'b0, ld_minor_abs, 1'b0};
      err_dec    <= {1'b0, ld_major_abs, 1'b0};
      err_acc    <= ERR_BITS'(0) - {3'b000, ld_major_abs};
      held_color <= line_color;
    end else if (ctl.step) begin
      major_pos <= next_major;
      if (minor_move) begin
        minor_pos <= next_minor;
        err_acc   <= err_sum - {1'b0, err_dec};
      end else begin
        err_acc   <= err_sum;
      end
    end
  end

  // Output register for the emitted pixel.
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      pix_x     <= cur_x;
      pix_y     <= cur_y;
      pix_addr  <= addr_sum[ADDR_BITS-1:0];
      pix_color <= held_color;
      last      <= sts.last;
    end
  end

endmodule

/* design/line_pixel_generator.sv */
`timescale 1ns / 1ps

// Integer line rasterizer. A load request (cmd = 0) gives two endpoints and a
// color; the block compares the absolute deltas to choose the major axis (x
// wins a tie) and arms its error term. Every step request (cmd = 1) on an
// active line emits one framebuffer write at pix_y * screen_width + pix_x,
// taken modulo 2^22, and advances one pixel. The second endpoint is never
// drawn, a zero-length line draws nothing, a step with no active line gives
// no pixel, and a load drops any line in progress. The final pixel carries
// last = 1. No clipping is done. The error update is one add, a sign test
// and one subtract, and the address uses one 11 by 12 bit multiply feeding
// the output register. A pixel appears on the output in the cycle after its
// step request is accepted, and requests can be taken on every cycle while
// in_stall is low. While a pixel sits in the output register with out_stall
// high, in_stall is raised. The screen_width register (byte address 0, reset
// 640) is written through the APB-style port and should be changed only
// while no line is being drawn. After reset no line is active.
module line_pixel_generator
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COLOR_BITS-1:0] line_color,
  // Pixel channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] pix_x,
  output logic [COORD_BITS-1:0] pix_y,
  output logic [ADDR_BITS-1:0]  pix_addr,
  output logic [COLOR_BITS-1:0] pix_color,
  output logic                  last,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  lpg_cmd_t    ctl;
  lpg_status_t sts;

  // The register file never inserts wait states.
  assign pready = 1'b1;

  // The controller tracks whether a line is active and owns both handshakes.
  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // The datapath holds the line state, the error arithmetic, the address
  // multiply and the pixel output register.
  lpg_datapath #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .line_color (line_color),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_addr   (pix_addr),
    .pix_color  (pix_color),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
  );

endmodule
